// ===== rtl/ihex_pkg.sv =====
package ihex_pkg;

    // one character beat
    typedef struct packed {
        logic [7:0] ch;
        logic       line_end;
    } t_in_item;

    // one result beat
    typedef struct packed {
        logic        kind;
        logic [31:0] write_addr;
        logic [7:0]  write_data;
        logic [1:0]  status;
        logic [7:0]  byte_count;
        logic        last;
    } t_out_item;

    // results of one character, handed to the output queue
    typedef struct packed {
        logic [1:0] cnt;
        t_out_item  item0;
        t_out_item  item1;
    } t_push;

    typedef enum logic [2:0] {
        PH_AWAIT = 3'd0,
        PH_LEN   = 3'd1,
        PH_ADDR  = 3'd2,
        PH_TYPE  = 3'd3,
        PH_ELA   = 3'd4,
        PH_DATA  = 3'd5,
        PH_SUM   = 3'd6,
        PH_SKIP  = 3'd7
    } t_phase;

    localparam logic KIND_WRITE  = 1'b0;
    localparam logic KIND_STATUS = 1'b1;

    localparam logic [1:0] ST_DATA_OK = 2'd0;
    localparam logic [1:0] ST_ELA_OK  = 2'd1;
    localparam logic [1:0] ST_IGNORED = 2'd2;
    localparam logic [1:0] ST_ERROR   = 2'd3;

    localparam logic [7:0] REC_DATA = 8'h00;
    localparam logic [7:0] REC_ELA  = 8'h04;
    localparam logic [7:0] CH_COLON = 8'h3A;

    // output queue: room for two results per character plus slack
    localparam int QDEPTH = 4;
    localparam int QAW    = 2;

endpackage

// ===== rtl/ihex_core.sv =====
module ihex_core (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_accept,
    input  ihex_pkg::t_in_item i_item,
    output ihex_pkg::t_push    o_push
);

    ihex_pkg::t_phase r_phase, n_phase;
    logic [1:0]  r_digit_pos, n_digit_pos;
    logic [3:0]  r_high_nibble, n_high_nibble;
    logic [7:0]  r_record_len, n_record_len;
    logic [15:0] r_record_addr, n_record_addr;
    logic [7:0]  r_record_type, n_record_type;
    logic [7:0]  r_data_index, n_data_index;
    logic [7:0]  r_running_sum, n_running_sum;
    logic [15:0] r_upper_address, n_upper_address;
    logic [15:0] r_field_value, n_field_value;

    logic       hex_ok;
    logic [3:0] hex_val;
    logic [7:0] byte_val;
    logic [7:0] sum_val;
    logic [7:0] index_inc;
    logic       in_record;
    logic       skip_beat;
    logic       await_bad;
    logic       bad_digit;
    logic       byte_done;
    logic       type_ignored;
    logic       data_write;
    logic       sum_done;
    logic       finished;
    logic       trunc;
    logic [1:0] fin_status;
    logic [7:0] fin_count;

    always_comb begin
        hex_ok  = 1'b1;
        hex_val = 4'd0;
        if (i_item.ch >= 8'h30 && i_item.ch <= 8'h39) begin
            hex_val = i_item.ch[3:0];
        end else if ((i_item.ch >= 8'h41 && i_item.ch <= 8'h46)
                  || (i_item.ch >= 8'h61 && i_item.ch <= 8'h66)) begin
            hex_val = i_item.ch[3:0] + 4'd9;
        end else begin
            hex_ok = 1'b0;
        end
    end

    assign byte_val  = {r_high_nibble, hex_val};
    assign sum_val   = r_running_sum + byte_val;
    assign index_inc = r_data_index + 8'd1;

    assign skip_beat    = (r_phase == ihex_pkg::PH_SKIP);
    assign in_record    = !skip_beat && (r_phase != ihex_pkg::PH_AWAIT);
    assign await_bad    = (r_phase == ihex_pkg::PH_AWAIT) && (i_item.ch != ihex_pkg::CH_COLON);
    assign bad_digit    = in_record && !hex_ok;
    assign byte_done    = in_record && hex_ok && r_digit_pos[0];
    assign type_ignored = byte_done && (r_phase == ihex_pkg::PH_TYPE)
                          && (byte_val != ihex_pkg::REC_ELA) && (byte_val != ihex_pkg::REC_DATA);
    assign data_write   = byte_done && (r_phase == ihex_pkg::PH_DATA);
    assign sum_done     = byte_done && (r_phase == ihex_pkg::PH_SUM);
    assign finished     = await_bad || bad_digit || type_ignored || sum_done;
    assign trunc        = !skip_beat && !finished && i_item.line_end;

    // next state
    always_comb begin
        n_phase         = r_phase;
        n_digit_pos     = r_digit_pos;
        n_high_nibble   = r_high_nibble;
        n_record_len    = r_record_len;
        n_record_addr   = r_record_addr;
        n_record_type   = r_record_type;
        n_data_index    = r_data_index;
        n_running_sum   = r_running_sum;
        n_upper_address = r_upper_address;
        n_field_value   = r_field_value;
        if (skip_beat) begin
            if (i_item.line_end) begin
                n_phase = ihex_pkg::PH_AWAIT;
            end
        end else begin
            if (r_phase == ihex_pkg::PH_AWAIT) begin
                if (!await_bad) begin
                    n_running_sum = 8'd0;
                    n_digit_pos   = 2'd0;
                    n_field_value = 16'd0;
                    n_data_index  = 8'd0;
                    n_phase       = ihex_pkg::PH_LEN;
                end
            end else if (hex_ok && !r_digit_pos[0]) begin
                n_high_nibble = hex_val;
                n_digit_pos   = r_digit_pos + 2'd1;
            end else if (hex_ok) begin
                n_running_sum = sum_val;
                n_digit_pos   = r_digit_pos + 2'd1;
                unique case (r_phase)
                    ihex_pkg::PH_LEN: begin
                        n_record_len = byte_val;
                        n_digit_pos  = 2'd0;
                        n_phase      = ihex_pkg::PH_ADDR;
                    end
                    ihex_pkg::PH_ADDR: begin
                        n_field_value = {r_field_value[7:0], byte_val};
                        if (r_digit_pos == 2'd3) begin
                            n_record_addr = {r_field_value[7:0], byte_val};
                            n_field_value = 16'd0;
                            n_digit_pos   = 2'd0;
                            n_phase       = ihex_pkg::PH_TYPE;
                        end
                    end
                    ihex_pkg::PH_TYPE: begin
                        n_record_type = byte_val;
                        n_digit_pos   = 2'd0;
                        if (byte_val == ihex_pkg::REC_ELA) begin
                            n_phase = ihex_pkg::PH_ELA;
                        end else if (byte_val == ihex_pkg::REC_DATA) begin
                            n_phase = (r_record_len != 8'd0) ? ihex_pkg::PH_DATA
                                                              : ihex_pkg::PH_SUM;
                        end
                    end
                    ihex_pkg::PH_ELA: begin
                        n_field_value = {r_field_value[7:0], byte_val};
                        if (r_digit_pos == 2'd3) begin
                            n_upper_address = {r_field_value[7:0], byte_val};
                            n_field_value   = 16'd0;
                            n_digit_pos     = 2'd0;
                            n_phase         = ihex_pkg::PH_SUM;
                        end
                    end
                    ihex_pkg::PH_DATA: begin
                        n_data_index = index_inc;
                        n_digit_pos  = 2'd0;
                        if (index_inc == r_record_len) begin
                            n_phase = ihex_pkg::PH_SUM;
                        end
                    end
                    default: begin
                        n_digit_pos = 2'd0;
                    end
                endcase
            end
            if (finished) begin
                n_phase = i_item.line_end ? ihex_pkg::PH_AWAIT : ihex_pkg::PH_SKIP;
            end else if (i_item.line_end) begin
                n_phase = ihex_pkg::PH_AWAIT;
            end
        end
    end

    // outputs
    always_comb begin
        fin_count = 8'd0;
        if (await_bad || bad_digit) begin
            fin_status = ihex_pkg::ST_ERROR;
        end else if (type_ignored) begin
            fin_status = ihex_pkg::ST_IGNORED;
        end else if (sum_val != 8'd0) begin
            fin_status = ihex_pkg::ST_ERROR;
        end else if (r_record_type == ihex_pkg::REC_ELA) begin
            fin_status = ihex_pkg::ST_ELA_OK;
        end else begin
            fin_status = ihex_pkg::ST_DATA_OK;
            fin_count  = r_record_len;
        end

        o_push       = '0;
        o_push.item0.kind = ihex_pkg::KIND_STATUS;
        o_push.item1.kind = ihex_pkg::KIND_STATUS;
        o_push.item1.status = ihex_pkg::ST_ERROR;
        o_push.item1.last   = 1'b1;
        if (data_write) begin
            o_push.item0.kind       = ihex_pkg::KIND_WRITE;
            o_push.item0.write_addr = {r_upper_address, r_record_addr} + {24'd0, r_data_index};
            o_push.item0.write_data = byte_val;
            o_push.item0.last       = !trunc;
        end else if (finished) begin
            o_push.item0.status     = fin_status;
            o_push.item0.byte_count = fin_count;
            o_push.item0.last       = 1'b1;
        end else begin
            o_push.item0.status = ihex_pkg::ST_ERROR;
            o_push.item0.last   = 1'b1;
        end
        if (i_accept) begin
            o_push.cnt = {1'b0, data_write || finished || trunc} + {1'b0, data_write && trunc};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase         <= ihex_pkg::PH_AWAIT;
            r_digit_pos     <= 2'd0;
            r_high_nibble   <= 4'd0;
            r_record_len    <= 8'd0;
            r_record_addr   <= 16'd0;
            r_record_type   <= 8'd0;
            r_data_index    <= 8'd0;
            r_running_sum   <= 8'd0;
            r_upper_address <= 16'd0;
            r_field_value   <= 16'd0;
        end else if (i_accept) begin
            r_phase         <= n_phase;
            r_digit_pos     <= n_digit_pos;
            r_high_nibble   <= n_high_nibble;
            r_record_len    <= n_record_len;
            r_record_addr   <= n_record_addr;
            r_record_type   <= n_record_type;
            r_data_index    <= n_data_index;
            r_running_sum   <= n_running_sum;
            r_upper_address <= n_upper_address;
            r_field_value   <= n_field_value;
        end
    end

endmodule

// ===== rtl/ihex_out_queue.sv =====
module ihex_out_queue (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  ihex_pkg::t_push     i_push,
    output logic                o_room,
    output logic                o_valid,
    input  logic                i_ready,
    output ihex_pkg::t_out_item o_item
);

    ihex_pkg::t_out_item r_mem [ihex_pkg::QDEPTH];

    logic [ihex_pkg::QAW-1:0] r_wr_ptr, n_wr_ptr;
    logic [ihex_pkg::QAW-1:0] r_rd_ptr, n_rd_ptr;
    logic [ihex_pkg::QAW:0]   r_count, n_count;
    logic [ihex_pkg::QAW-1:0] wr_ptr1;
    logic                     pop;

    assign wr_ptr1 = r_wr_ptr + ihex_pkg::QAW'(1);
    assign o_valid = (r_count != '0);
    assign o_item  = r_mem[r_rd_ptr];
    assign pop     = o_valid && i_ready;
    // a character can leave up to two results
    assign o_room  = (r_count <= (ihex_pkg::QAW + 1)'(ihex_pkg::QDEPTH - 2));

    assign n_wr_ptr = r_wr_ptr + ihex_pkg::QAW'(i_push.cnt);
    assign n_rd_ptr = r_rd_ptr + ihex_pkg::QAW'(pop);
    assign n_count  = r_count + (ihex_pkg::QAW + 1)'(i_push.cnt)
                      - (ihex_pkg::QAW + 1)'(pop);

    always_ff @(posedge i_clk) begin
        if (i_push.cnt != 2'd0) begin
            r_mem[r_wr_ptr] <= i_push.item0;
        end
        if (i_push.cnt == 2'd2) begin
            r_mem[wr_ptr1] <= i_push.item1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

endmodule

// ===== rtl/intel_hex_record_decoder.sv =====
// intel hex record decoder: takes one ascii character per beat, with line_end on
// the last character of each line, and produces memory write beats (kind 0) for
// each data byte of a type 00 record and one status beat (kind 1) per line:
// data ok with byte count, ela ok, record ignored, or error (missing colon, bad
// digit, truncated line, checksum mismatch). writes leave as soon as their byte
// is parsed, before the checksum is known. the upper address set by a type 04
// record persists across lines until the next one. a character is taken every
// cycle while ready holds: the parser state updates in the accepting cycle and
// its results land in a four-entry output queue. at most two results come from
// one character (a data byte that ends a truncated line), so ready holds while
// the queue has two free entries; with a stalled output side, the input side
// stalls once the queue fills. results reach the output from queue registers.
module intel_hex_record_decoder (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_ready,
    input  ihex_pkg::t_in_item  i_in_item,
    output logic                o_out_valid,
    input  logic                i_out_ready,
    output ihex_pkg::t_out_item o_out_item
);

    logic            in_accept;
    logic            q_room;
    ihex_pkg::t_push push;

    // input beat taken only when the queue can absorb its worst case
    assign o_in_ready = q_room;
    assign in_accept  = i_in_valid && q_room;

    // parser state and per-character result generation
    ihex_core u_core (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_accept (in_accept),
        .i_item   (i_in_item),
        .o_push   (push)
    );

    // result buffer decoupling the output handshake
    ihex_out_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .o_room  (q_room),
        .o_valid (o_out_valid),
        .i_ready (i_out_ready),
        .o_item  (o_out_item)
    );

endmodule

// ===== bench/ihex_beat_checker.sv =====
`timescale 1ns / 100ps

module ihex_beat_checker (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    input  logic                i_in_ready,
    input  ihex_pkg::t_in_item  i_in_item,
    input  logic                i_out_valid,
    input  logic                i_out_ready,
    input  ihex_pkg::t_out_item i_out_item,
    output int                  o_fail_count,
    output int                  o_pending,
    output int                  o_write_beats,
    output int                  o_status_beats,
    output int                  o_error_beats
);
    import ihex_pkg::*;

    // parser state, kept apart from the block
    t_phase      phase      = PH_AWAIT;
    logic [1:0]  digit_pos  = '0;
    logic [3:0]  high_nib   = '0;
    logic [7:0]  rec_len    = '0;
    logic [7:0]  rec_type   = '0;
    logic [7:0]  data_idx   = '0;
    logic [7:0]  csum       = '0;
    logic [15:0] rec_addr   = '0;
    logic [15:0] upper_addr = '0;
    logic [15:0] field_acc  = '0;

    t_out_item   expected_beats [$];
    int          fails    = 0;
    int          writes   = 0;
    int          statuses = 0;
    int          errors   = 0;

    function automatic int hex_value(logic [7:0] c);
        if (c >= "0" && c <= "9") return int'(c) - int'("0");
        if (c >= "A" && c <= "F") return int'(c) - int'("A") + 10;
        if (c >= "a" && c <= "f") return int'(c) - int'("a") + 10;
        return -1;
    endfunction

    function automatic t_out_item status_beat(logic [1:0] st, logic [7:0] cnt);
        t_out_item b;
        b            = '0;
        b.kind       = KIND_STATUS;
        b.status     = st;
        b.byte_count = cnt;
        return b;
    endfunction

    function automatic t_out_item write_beat(logic [31:0] addr, logic [7:0] data);
        t_out_item b;
        b            = '0;
        b.kind       = KIND_WRITE;
        b.write_addr = addr;
        b.write_data = data;
        return b;
    endfunction

    function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
        if (got !== want) begin
            $error("%s mismatch: expected 0x%0h, got 0x%0h", name, want, got);
            fails++;
        end
    endfunction

    // works out the beats that one character causes
    task automatic decode_char(input logic [7:0] c, input logic eol);
        t_out_item   beats [0:1];
        int          n;
        int          v;
        logic        done;
        logic [7:0]  b;
        logic [1:0]  pos;
        logic [31:0] base;
        n    = 0;
        done = 1'b0;
        if (phase == PH_SKIP) begin
            if (eol) phase = PH_AWAIT;
        end else begin
            if (phase == PH_AWAIT) begin
                if (c != CH_COLON) begin
                    beats[n] = status_beat(ST_ERROR, 8'd0);
                    n++;
                    done = 1'b1;
                end else begin
                    csum      = '0;
                    digit_pos = '0;
                    field_acc = '0;
                    data_idx  = '0;
                    phase     = PH_LEN;
                end
            end else begin
                v = hex_value(c);
                if (v < 0) begin
                    beats[n] = status_beat(ST_ERROR, 8'd0);
                    n++;
                    done = 1'b1;
                end else if (!digit_pos[0]) begin
                    high_nib  = v[3:0];
                    digit_pos = digit_pos + 2'd1;
                end else begin
                    b         = {high_nib, v[3:0]};
                    pos       = digit_pos;
                    csum      = csum + b;
                    digit_pos = digit_pos + 2'd1;
                    case (phase)
                        PH_LEN: begin
                            rec_len   = b;
                            digit_pos = '0;
                            phase     = PH_ADDR;
                        end
                        PH_ADDR: begin
                            field_acc = {field_acc[7:0], b};
                            if (pos == 2'd3) begin
                                rec_addr  = field_acc;
                                field_acc = '0;
                                digit_pos = '0;
                                phase     = PH_TYPE;
                            end
                        end
                        PH_TYPE: begin
                            rec_type  = b;
                            digit_pos = '0;
                            if (b == REC_ELA) begin
                                phase = PH_ELA;
                            end else if (b == REC_DATA) begin
                                phase = (rec_len != 8'd0) ? PH_DATA : PH_SUM;
                            end else begin
                                beats[n] = status_beat(ST_IGNORED, 8'd0);
                                n++;
                                done = 1'b1;
                            end
                        end
                        PH_ELA: begin
                            field_acc = {field_acc[7:0], b};
                            if (pos == 2'd3) begin
                                upper_addr = field_acc;
                                field_acc  = '0;
                                digit_pos  = '0;
                                phase      = PH_SUM;
                            end
                        end
                        PH_DATA: begin
                            base     = {upper_addr, rec_addr};
                            beats[n] = write_beat(base + {24'd0, data_idx}, b);
                            n++;
                            data_idx  = data_idx + 8'd1;
                            digit_pos = '0;
                            if (data_idx == rec_len) phase = PH_SUM;
                        end
                        default: begin
                            digit_pos = '0;
                            if (csum != 8'd0) beats[n] = status_beat(ST_ERROR, 8'd0);
                            else if (rec_type == REC_ELA) beats[n] = status_beat(ST_ELA_OK, 8'd0);
                            else beats[n] = status_beat(ST_DATA_OK, rec_len);
                            n++;
                            done = 1'b1;
                        end
                    endcase
                end
            end
            if (done) begin
                phase = eol ? PH_AWAIT : PH_SKIP;
            end else if (eol) begin
                beats[n] = status_beat(ST_ERROR, 8'd0);
                n++;
                phase = PH_AWAIT;
            end
            if (n > 0) beats[n-1].last = 1'b1;
            for (int i = 0; i < n; i++) expected_beats.push_back(beats[i]);
        end
    endtask

    always @(posedge i_clk) begin
        t_out_item want;
        if (!i_rst_n) begin
            phase      = PH_AWAIT;
            digit_pos  = '0;
            high_nib   = '0;
            rec_len    = '0;
            rec_type   = '0;
            data_idx   = '0;
            csum       = '0;
            rec_addr   = '0;
            upper_addr = '0;
            field_acc  = '0;
            expected_beats.delete();
        end else begin
            if (i_out_valid && i_out_ready) begin
                if (expected_beats.size() == 0) begin
                    $error("result beat with nothing expected: kind %0d status %0d",
                           i_out_item.kind, i_out_item.status);
                    fails++;
                end else begin
                    want = expected_beats.pop_front();
                    check_field("kind", 32'(want.kind), 32'(i_out_item.kind));
                    check_field("write_addr", want.write_addr, i_out_item.write_addr);
                    check_field("write_data", 32'(want.write_data),
                                32'(i_out_item.write_data));
                    check_field("status", 32'(want.status), 32'(i_out_item.status));
                    check_field("byte_count", 32'(want.byte_count),
                                32'(i_out_item.byte_count));
                    check_field("last", 32'(want.last), 32'(i_out_item.last));
                end
                if (i_out_item.kind == KIND_WRITE) begin
                    writes++;
                end else begin
                    statuses++;
                    if (i_out_item.status == ST_ERROR) errors++;
                end
            end
            if (i_in_valid && i_in_ready) decode_char(i_in_item.ch, i_in_item.line_end);
        end
        o_fail_count   <= fails;
        o_pending      <= expected_beats.size();
        o_write_beats  <= writes;
        o_status_beats <= statuses;
        o_error_beats  <= errors;
    end

endmodule

// ===== bench/intel_hex_record_decoder_tb.sv =====
`timescale 1ns / 100ps

module intel_hex_record_decoder_tb;
    import ihex_pkg::*;

    localparam int CYCLE_LIMIT  = 600000;
    localparam int RANDOM_CHARS = 190;
    localparam int DRAIN_CYCLES = 20;

    logic      i_clk     = 1'b0;
    logic      i_rst_n   = 1'b0;
    logic      in_valid  = 1'b0;
    logic      out_ready = 1'b0;
    t_in_item  in_item   = '0;
    logic      in_ready;
    logic      out_valid;
    t_out_item out_item;

    int fail_count;
    int pending;
    int write_beats;
    int status_beats;
    int error_beats;

    int cycles     = 0;
    int chars_sent = 0;
    int lines_sent = 0;
    int stall_left = 0;

    // idling switches, flipped now and then so some stretches run flat out
    bit idle_on  = 1'b1;
    bit stall_on = 1'b1;

    // characters of the line being built, and data bytes of the record
    logic [7:0] line_q   [$];
    logic [7:0] rec_data [$];
    int         digit_case;   // 0 upper, 1 lower, 2 mixed per digit

    // clock: 10 ns period
    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    intel_hex_record_decoder dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (in_valid),
        .o_in_ready  (in_ready),
        .i_in_item   (in_item),
        .o_out_valid (out_valid),
        .i_out_ready (out_ready),
        .o_out_item  (out_item)
    );

    // watches both channels, predicts every beat and compares
    ihex_beat_checker u_checker (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (in_valid),
        .i_in_ready     (in_ready),
        .i_in_item      (in_item),
        .i_out_valid    (out_valid),
        .i_out_ready    (out_ready),
        .i_out_item     (out_item),
        .o_fail_count   (fail_count),
        .o_pending      (pending),
        .o_write_beats  (write_beats),
        .o_status_beats (status_beats),
        .o_error_beats  (error_beats)
    );

    // watchdog
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT) begin
            $display("intel_hex_record_decoder test failed");
            $finish;
        end
    end

    // idle length: mostly from the short range, now and then a long one
    function automatic int gap_len();
        if ($urandom_range(0, 99) < 85) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    // result side back-pressure, changed only at the falling edge
    always @(negedge i_clk) begin
        if (stall_left > 0) begin
            out_ready  <= 1'b0;
            stall_left <= stall_left - 1;
        end else if (stall_on && $urandom_range(0, 99) < 25) begin
            out_ready  <= 1'b0;
            stall_left <= gap_len() - 1;
        end else begin
            out_ready <= 1'b1;
        end
    end

    function automatic logic [7:0] hex_char(logic [3:0] nib, bit lower);
        if (nib < 4'd10) return 8'h30 + {4'd0, nib};
        return (lower ? 8'h61 : 8'h41) + {4'd0, nib} - 8'd10;
    endfunction

    task automatic put_byte(input logic [7:0] b);
        bit lower_hi;
        bit lower_lo;
        lower_hi = (digit_case == 1) || (digit_case == 2 && $urandom_range(0, 1) == 1);
        lower_lo = (digit_case == 1) || (digit_case == 2 && $urandom_range(0, 1) == 1);
        line_q.push_back(hex_char(b[7:4], lower_hi));
        line_q.push_back(hex_char(b[3:0], lower_lo));
    endtask

    // full record line from rec_data; sum_flip nonzero spoils the checksum
    task automatic put_record(input logic [7:0] len, input logic [15:0] addr,
                              input logic [7:0] rtype, input logic [7:0] sum_flip);
        logic [7:0] sum;
        line_q.delete();
        line_q.push_back(CH_COLON);
        sum = len + addr[15:8] + addr[7:0] + rtype;
        put_byte(len);
        put_byte(addr[15:8]);
        put_byte(addr[7:0]);
        put_byte(rtype);
        foreach (rec_data[i]) begin
            sum = sum + rec_data[i];
            put_byte(rec_data[i]);
        end
        put_byte((8'd0 - sum) ^ sum_flip);
    endtask

    task automatic put_text(input string s);
        line_q.delete();
        for (int i = 0; i < s.len(); i++) line_q.push_back(s[i]);
    endtask

    // one character beat; valid stays up afterwards so back to back beats
    // need no drop, whoever idles next lowers it
    task automatic send_char(input logic [7:0] c, input logic eol);
        int gap;
        gap = (idle_on && $urandom_range(0, 99) < 30) ? gap_len() : 0;
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        in_valid     <= 1'b1;
        in_item.ch       <= c;
        in_item.line_end <= eol;
        @(posedge i_clk);
        while (!in_ready) @(posedge i_clk);
        chars_sent++;
        @(negedge i_clk);
    endtask

    task automatic send_line();
        for (int i = 0; i < line_q.size(); i++) send_char(line_q[i], i == line_q.size() - 1);
        lines_sent++;
        idle_on  <= ($urandom_range(0, 3) != 0);
        stall_on <= ($urandom_range(0, 3) != 0);
    endtask

    // hold the sender until every predicted beat has come out
    task automatic wait_drained();
        in_valid <= 1'b0;
        while (pending != 0) @(negedge i_clk);
    endtask

    task automatic fill_data(input int count);
        rec_data.delete();
        repeat (count) rec_data.push_back(8'($urandom_range(0, 255)));
    endtask

    task automatic run_directed();
        digit_case = 0;
        // ela to zero, the plain case
        put_text(":020000040000FA");
        send_line();
        // one byte at the top of the low segment, data all ones
        rec_data = '{8'hFF};
        put_record(8'd1, 16'hFFFF, REC_DATA, 8'h00);
        send_line();
        // upper address all ones, lower case digits
        digit_case = 1;
        rec_data   = '{8'hFF, 8'hFF};
        put_record(8'd2, 16'h0000, REC_ELA, 8'h00);
        send_line();
        // two bytes at ffffffff: the second wraps to zero
        digit_case = 2;
        rec_data   = '{8'h00, 8'hA5};
        put_record(8'd2, 16'hFFFF, REC_DATA, 8'h00);
        send_line();
        // zero length data record: checksum right after the type
        put_text(":0000000000");
        send_line();
        // end of file record is reported as ignored, checksum skipped
        put_text(":00000001FF");
        send_line();
        // highest record type, also ignored
        rec_data.delete();
        put_record(8'd0, 16'h1234, 8'hFF, 8'h00);
        send_line();
        // missing colon, then one-character lines of extreme codes
        put_text("X:00");
        send_line();
        line_q = '{8'hFF};
        send_line();
        line_q = '{8'h00};
        send_line();
        // bad digit in the length, bad digit in the data
        put_text(":0G000000");
        send_line();
        put_text(":0300000011/2");
        send_line();
        // truncated right after a data byte: write then error on one character
        put_text(":0300000011");
        send_line();
        // colon alone
        put_text(":");
        send_line();
        // checksum mismatch on a data record
        fill_data(3);
        put_record(8'd3, 16'h0100, REC_DATA, 8'h01);
        send_line();
        // ela with bad checksum still moves the upper address
        rec_data = '{8'h12, 8'h34};
        put_record(8'd2, 16'h0000, REC_ELA, 8'h80);
        send_line();
        rec_data = '{8'h5A};
        put_record(8'd1, 16'h0010, REC_DATA, 8'h00);
        send_line();
        // text after a complete record is skipped silently
        put_text(":0000000000zz!");
        send_line();
        // ela cut off inside the checksum
        put_text(":020000040000F");
        send_line();
        // back to upper zero
        put_text(":020000040000fa");
        send_line();
        // long record
        fill_data(64);
        put_record(8'd64, 16'h8000, REC_DATA, 8'h00);
        send_line();
        // noise with bit 7 set and a stray colon
        line_q = '{8'h80, 8'h7F, CH_COLON, 8'hC0};
        send_line();
    endtask

    task automatic random_line();
        int         r;
        int         cut;
        logic [7:0] rtype;
        logic [7:0] flip;
        logic [15:0] addr;
        r          = $urandom_range(0, 99);
        digit_case = $urandom_range(0, 2);
        flip       = ($urandom_range(0, 9) == 0) ? 8'($urandom_range(1, 255)) : 8'h00;
        addr       = 16'($urandom_range(0, 16'hFFFF));
        if ($urandom_range(0, 5) == 0) addr[15:4] = 12'hFFF;
        if (r < 55) begin
            // data records, mostly short
            fill_data(($urandom_range(0, 9) == 0) ? $urandom_range(17, 40)
                                                  : $urandom_range(0, 16));
            put_record(8'(rec_data.size()), addr, REC_DATA, flip);
        end else if (r < 70) begin
            rec_data.delete();
            case ($urandom_range(0, 3))
                0:       rec_data = '{8'h00, 8'h00};
                1:       rec_data = '{8'hFF, 8'hFF};
                default: fill_data(2);
            endcase
            put_record(8'd2, ($urandom_range(0, 3) == 0) ? addr : 16'h0000, REC_ELA, flip);
        end else if (r < 80) begin
            rtype = 8'($urandom_range(0, 255));
            if (rtype == REC_DATA || rtype == REC_ELA) rtype = 8'h01;
            fill_data($urandom_range(0, 4));
            put_record(8'(rec_data.size()), addr, rtype, 8'h00);
        end else begin
            // noise, sometimes behind a colon
            line_q.delete();
            if ($urandom_range(0, 1) == 1) line_q.push_back(CH_COLON);
            repeat ($urandom_range(1, 6)) line_q.push_back(8'($urandom_range(0, 255)));
        end
        if (r < 80) begin
            // break some well formed lines: truncation, a bad character, trailing text
            case ($urandom_range(0, 9))
                0: begin
                    cut = $urandom_range(1, line_q.size() - 1);
                    while (line_q.size() > cut) line_q.pop_back();
                end
                1: line_q[$urandom_range(1, line_q.size() - 1)] = 8'($urandom_range(0, 255));
                2: repeat ($urandom_range(1, 4)) line_q.push_back(8'($urandom_range(0, 255)));
                default: ;
            endcase
        end
        send_line();
    endtask

    initial begin
        int start_chars;
        // synchronous reset held from the start, released at a falling edge
        repeat (12) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        run_directed();
        wait_drained();

        start_chars = chars_sent;
        while (chars_sent - start_chars < RANDOM_CHARS) begin
            random_line();
            if ($urandom_range(0, 11) == 0) wait_drained();
        end

        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("%0d lines, %0d characters sent; %0d write and %0d status beats checked",
                 lines_sent, chars_sent, write_beats, status_beats);
        $display("%0d error statuses among them, %0d mismatches", error_beats, fail_count);
        if (fail_count == 0) begin
            $display("intel_hex_record_decoder test passed");
        end else begin
            $display("intel_hex_record_decoder test failed");
        end
        $finish;
    end

endmodule

// ===== filelist.f =====
rtl/ihex_pkg.sv
rtl/ihex_core.sv
rtl/ihex_out_queue.sv
rtl/intel_hex_record_decoder.sv
bench/ihex_beat_checker.sv
bench/intel_hex_record_decoder_tb.sv
